// File: src/checksum_frame_receiver_unit_assert.svh
// Assertion macros shared by the frame receiver RTL.
// Each macro takes a label, the clock, the active-low reset, the
// antecedent, the consequent and a message string.
`ifndef CHECKSUM_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define CHECKSUM_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CRFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/crfu_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Types and fixed constants for the header and checksum deframer.
// ----------------------------------------------------------------------------
package crfu_pkg;

  localparam int unsigned FrameLen   = 9;
  localparam int unsigned WinLen     = FrameLen - 1;
  localparam int unsigned PayloadLen = 7;
  localparam int unsigned FillW      = $clog2(WinLen + 1);
  localparam int unsigned IdxW       = $clog2(WinLen);
  localparam int unsigned PayloadW   = PayloadLen * 8;

  localparam logic [7:0] HeaderReset = 8'h55;

  typedef logic [7:0]            byte_t;
  typedef byte_t [WinLen-1:0]    win_t;
  typedef logic [PayloadW-1:0]   payload_t;
  typedef logic [FillW-1:0]      fill_t;

  // Verdict of the frame check on a full window plus the arriving byte.
  typedef struct packed {
    logic     header_ok;
    logic     sum_ok;
    payload_t payload;
  } check_t;

endpackage

// File: src/checksum_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Checksum frame receiver
// Finds nine-byte frames with a header byte and an additive checksum.
// ----------------------------------------------------------------------------
// Received bytes arrive one beat per cycle on the input channel and fill an
// eight-byte window. The beat that would complete nine bytes is checked on
// arrival: the oldest window byte must match the header register and the
// modulo-256 sum of the eight window bytes must equal the arriving byte. On a
// match the seven payload bytes (first received in the top byte) go to the
// output register and the window empties; otherwise the window slides by one
// byte, so the receiver resynchronizes on the next candidate header. The
// window and the output register are the only stages, and a new byte is
// taken each cycle unless a finished payload is waiting in the output
// register while the output side stalls. The header register resets to
// 0x55 and should be written only while the link is quiet.
module checksum_frame_receiver_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crfu_pkg::byte_t     rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crfu_pkg::payload_t  payload_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  crfu_pkg::byte_t     cfg_header_value_i
);
  import crfu_pkg::*;

  `include "checksum_frame_receiver_unit_assert.svh"

  byte_t    header_q;
  win_t     win_q, win_d;
  fill_t    fill_q, fill_d;
  logic     out_valid_q, out_valid_d;
  payload_t payload_q;
  check_t   check;
  logic     in_fire, win_full, frame_hit;

  // The header register is always writable.
  assign cfg_ready_o = 1'b1;

  // Only a waiting payload that cannot leave holds the input back.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign win_full   = (fill_q == fill_t'(WinLen));

  crfu_check u_check (
    .win_i     (win_q),
    .rx_byte_i (rx_byte_i),
    .header_i  (header_q),
    .check_o   (check)
  );

  assign frame_hit = in_fire & win_full & check.header_ok & check.sum_ok;

  // Window update: append while filling, empty on a frame, slide otherwise.
  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (in_fire) begin
      if (!win_full) begin
        win_d[fill_q[IdxW-1:0]] = rx_byte_i;
        fill_d = fill_q + fill_t'(1);
      end else if (frame_hit) begin
        fill_d = '0;
      end else begin
        for (int k = 0; k < WinLen - 1; k++) begin
          win_d[k] = win_q[k+1];
        end
        win_d[WinLen-1] = rx_byte_i;
      end
    end
  end

  // The output slot empties when taken and refills on a frame.
  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (frame_hit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= HeaderReset;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        header_q <= cfg_header_value_i;
      end
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Window bytes beyond the fill count are never read, so no reset is needed.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (frame_hit) begin
      payload_q <= check.payload;
    end
  end

  assign out_valid_o = out_valid_q;
  assign payload_o   = payload_q;

  `CRFU_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= fill_t'(WinLen), "fill count beyond window")
  `CRFU_ASSERT_NEXT(a_hit_empties, clk_i, rst_ni, frame_hit, out_valid_q && fill_q == '0, "frame did not empty window or post payload")
  `CRFU_ASSERT_NEXT(a_fill_step, clk_i, rst_ni, in_fire && !win_full, fill_q == $past(fill_q) + fill_t'(1), "fill count did not advance")
  `CRFU_ASSERT_NEXT(a_slide_full, clk_i, rst_ni, in_fire && win_full && !frame_hit, fill_q == fill_t'(WinLen) && !$rose(out_valid_q), "rejected frame changed fill or posted payload")

endmodule

// File: src/crfu_check.sv
// ----------------------------------------------------------------------------
// Frame check
// Compares the oldest byte with the header and the byte sum with the checksum.
// ----------------------------------------------------------------------------
module crfu_check (
  input  crfu_pkg::win_t   win_i,
  input  crfu_pkg::byte_t  rx_byte_i,
  input  crfu_pkg::byte_t  header_i,
  output crfu_pkg::check_t check_o
);
  import crfu_pkg::*;

  byte_t sum;

  // Modulo-256 sum of the eight oldest bytes.
  always_comb begin
    sum = '0;
    for (int k = 0; k < WinLen; k++) begin
      sum = sum + win_i[k];
    end
  end

  always_comb begin
    check_o.header_ok = (win_i[0] == header_i);
    check_o.sum_ok    = (sum == rx_byte_i);
    for (int k = 0; k < PayloadLen; k++) begin
      check_o.payload[(PayloadLen-1-k)*8 +: 8] = win_i[k+1];
    end
  end

endmodule
